// ----- rtl/swmf_pkg.sv -----
`timescale 1ns / 1ps

package swmf_pkg;

  // Window geometry
  localparam int WIN_LEN  = 9;
  localparam int SAMPLE_W = 16;
  localparam int AGE_W    = 4;
  localparam int IDX_W    = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int MED_IDX  = WIN_LEN / 2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // Age carried by the entry that the next sample replaces
  localparam age_t OLDEST_AGE = AGE_W'(WIN_LEN - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEFT,
    ST_RIGHT,
    ST_OUT
  } swmf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step_left;
    logic step_right;
    logic capture;
  } swmf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic left_swap;
    logic right_swap;
    logic out_free;
  } swmf_sts_t;

endpackage

// ----- rtl/swmf_stream_if.sv -----
`timescale 1ns / 1ps

// Sample channel
interface swmf_sample_if;
  logic                      valid;
  logic                      ready;
  logic [swmf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Median channel
interface swmf_median_if;
  logic                      valid;
  logic                      ready;
  logic [swmf_pkg::SAMPLE_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ----- rtl/swmf_datapath.sv -----
`timescale 1ns / 1ps

module swmf_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  swmf_pkg::swmf_cmd_t cmd,
  output swmf_pkg::swmf_sts_t sts,
  input  swmf_pkg::sample_t   sample,
  output swmf_pkg::sample_t   median,
  output logic                out_valid,
  input  logic                out_ready
);
  import swmf_pkg::*;

  sample_t vals_r [WIN_LEN];
  age_t    ages_r [WIN_LEN];
  idx_t    ptr_r;
  sample_t median_r;
  logic    out_valid_r;

  idx_t               victim;
  logic [WIN_LEN-1:0] lt_prev;  // entry below its left neighbor
  logic [WIN_LEN-1:0] lt_next;  // right neighbor below this entry

  // Pick the oldest entry, highest index wins, entry 0 if none
  always_comb begin
    victim = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (ages_r[i] == OLDEST_AGE) victim = IDX_W'(i);
    end
  end

  // Compare each entry with both of its neighbors
  genvar g;
  generate
    for (g = 0; g < WIN_LEN; g++) begin : g_cmp
      if (g > 0) begin : g_lt
        assign lt_prev[g] = vals_r[g] < vals_r[g-1];
      end else begin : g_lt0
        assign lt_prev[g] = 1'b0;
      end
      if (g < WIN_LEN - 1) begin : g_nx
        assign lt_next[g] = vals_r[g+1] < vals_r[g];
      end else begin : g_nx_last
        assign lt_next[g] = 1'b0;
      end
    end
  endgenerate

  assign sts.left_swap  = lt_prev[ptr_r];
  assign sts.right_swap = lt_next[ptr_r];
  assign sts.out_free   = !out_valid_r || out_ready;

  // Per-entry update: insert, then swap the moving sample one place a step
  generate
    for (g = 0; g < WIN_LEN; g++) begin : g_entry
      sample_t lo_v, hi_v;
      age_t    lo_a, hi_a;

      if (g > 0) begin : g_lo
        assign lo_v = vals_r[g-1];
        assign lo_a = ages_r[g-1];
      end else begin : g_lo0
        assign lo_v = vals_r[g];
        assign lo_a = ages_r[g];
      end
      if (g < WIN_LEN - 1) begin : g_hi
        assign hi_v = vals_r[g+1];
        assign hi_a = ages_r[g+1];
      end else begin : g_hi_last
        assign hi_v = vals_r[g];
        assign hi_a = ages_r[g];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vals_r[g] <= '0;
          ages_r[g] <= AGE_W'(g);
        end else if (cmd.load) begin
          if (IDX_W'(g) == victim) begin
            vals_r[g] <= sample;
            ages_r[g] <= '0;
          end else if (ages_r[g] != OLDEST_AGE) begin
            ages_r[g] <= ages_r[g] + 1'b1;
          end
        end else if (cmd.step_left) begin
          if (IDX_W'(g) == ptr_r) begin
            vals_r[g] <= lo_v;
            ages_r[g] <= lo_a;
          end else if (IDX_W'(g + 1) == ptr_r) begin
            vals_r[g] <= hi_v;
            ages_r[g] <= hi_a;
          end
        end else if (cmd.step_right) begin
          if (IDX_W'(g) == ptr_r) begin
            vals_r[g] <= hi_v;
            ages_r[g] <= hi_a;
          end else if (g > 0 && IDX_W'(g - 1) == ptr_r) begin
            vals_r[g] <= lo_v;
            ages_r[g] <= lo_a;
          end
        end
      end
    end
  endgenerate

  // Track the position of the new sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.load) begin
      ptr_r <= victim;
    end else if (cmd.step_left) begin
      ptr_r <= ptr_r - 1'b1;
    end else if (cmd.step_right) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // Output register: hold the median until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.capture) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) median_r <= vals_r[MED_IDX];
  end

  assign median    = median_r;
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/swmf_ctrl.sv -----
`timescale 1ns / 1ps

module swmf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swmf_pkg::swmf_sts_t sts,
  output swmf_pkg::swmf_cmd_t cmd
);
  import swmf_pkg::*;

  swmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid)        state_nxt = ST_LEFT;
      ST_LEFT:  if (!sts.left_swap)  state_nxt = ST_RIGHT;
      ST_RIGHT: if (!sts.right_swap) state_nxt = ST_OUT;
      ST_OUT:   if (sts.out_free)    state_nxt = ST_IDLE;
      default:                       state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_LEFT:  cmd.step_left  = sts.left_swap;
      ST_RIGHT: cmd.step_right = sts.right_swap;
      ST_OUT:   cmd.capture    = sts.out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/sliding_window_median_filter.sv -----
`timescale 1ns / 1ps

// Sliding-window median over the last nine 16-bit range samples.
// in_chan carries one sample per beat; out_chan returns exactly one median
// per accepted sample, in order. Both use valid/ready, a beat moving at a
// rising edge with both high.
// Each sample replaces the oldest window entry; compare-and-swap steps
// then walk the new sample left or right, one place per cycle, until the
// window is sorted again. The median is then loaded into the output register.
// The new sample moves 0 to 8 places. in_chan.ready is high only while the
// block is idle, so the next sample is taken only once the median of the
// last one is in the output register. A new sample is taken while a finished
// median still waits; if the receiver stalls, the next median holds in the
// block until the output register frees, and in_chan.ready stays low
// meanwhile.
// Reset (rst_n low, synchronous) clears the window to zero with entry i
// holding age i, and drops any pending median.
module sliding_window_median_filter (
  input  logic                 clk,
  input  logic                 rst_n,
  swmf_sample_if.sink          in_chan,
  swmf_median_if.source        out_chan
);
  import swmf_pkg::*;

  swmf_cmd_t cmd;
  swmf_sts_t sts;

  swmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_chan.sample),
    .median    (out_chan.median),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready)
  );

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step_left, cmd.step_right, cmd.capture}))
    else $error("more than one datapath command");

  // Never overwrite a median that is still waiting
  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (!out_chan.valid || out_chan.ready))
    else $error("capture over pending median");

  // One sample at a time
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("sample accepted while busy");

  // Captured median is presented next cycle
  a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_chan.valid)
    else $error("captured median not presented");

endmodule
